[hdl/cto_pkg.sv]
// ----------------------------------------------------------------------------
// cto_pkg
// Shared types and constants for the connection timeout table.
// ----------------------------------------------------------------------------
package cto_pkg;

  localparam int MAX_CONN_DEFAULT = 64;
  localparam int TIME_W = 32;
  localparam int NT_W = 25;
  localparam logic [NT_W-1:0] NEXT_MAX = 25'd16777215;
  localparam logic [NT_W-1:0] NEXT_NONE = '1;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_REPLACED = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PICK
  } state_t;

endpackage

[hdl/cto_ram.sv]
// ----------------------------------------------------------------------------
// cto_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module cto_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/connection_timeout_table_top.sv]
// ----------------------------------------------------------------------------
// connection_timeout_table_top
// Per-connection millisecond timers; expiry times kept in a RAM, armed bits
// in flops. Ticks emit due ids oldest first.
// ----------------------------------------------------------------------------
// Add/remove/idle tick: one result word after one RAM sweep computing the
// earliest expiry.
// Tick with N due ids: one sweep, then one further sweep per id; the sweeps
// run one after another because of the single RAM read port.
// Reset: time zero, all slots disarmed; no clearing pass is needed.
// Results cannot be stalled: done is high for one cycle per word.
module connection_timeout_table_top #(
  parameter int MAX_CONNECTIONS = cto_pkg::MAX_CONN_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [5:0]  connection_id,
  input  logic [23:0] timeout_ms,
  output logic        done,
  output logic        expired_valid,
  output logic [5:0]  expired_id,
  output logic        last,
  output logic [1:0]  status,
  output logic signed [24:0] next_timeout,
  output logic [6:0]  armed_count
);

  localparam int IW = $clog2(MAX_CONNECTIONS);
  localparam int CW = $clog2(MAX_CONNECTIONS + 1);
  localparam int NT_W_FIX = cto_pkg::NT_W;

  cto_pkg::state_t state, state_next;

  logic [31:0] time_now;
  logic [MAX_CONNECTIONS-1:0] armed;
  logic [MAX_CONNECTIONS-1:0] due;
  logic [6:0]  count, count_next;
  logic [6:0]  pending, pending_next;
  logic        is_tick;
  logic [1:0]  cmd_status;
  logic        any, any_next;
  logic signed [31:0] best, best_next;
  logic        found, found_next;
  logic [31:0] best_age, best_age_next;
  logic [IW-1:0] pick, pick_next;

  logic [CW-1:0] cnt;
  logic          rd_vld;
  logic [IW-1:0] rd_idx;
  logic [31:0]   rdata;

  logic          accept;
  logic          in_range;
  logic [IW-1:0] cid;
  logic          sweep_end;
  logic [31:0]   age;
  logic signed [31:0] gap;
  logic          due_hit;
  logic [NT_W_FIX-1:0] nt_val;

  assign busy = (state != cto_pkg::S_IDLE);
  assign accept = start && !busy;
  assign in_range = ({1'b0, connection_id} < 7'(MAX_CONNECTIONS));
  assign cid = connection_id[IW-1:0];
  assign sweep_end = (cnt == CW'(MAX_CONNECTIONS));
  assign age = time_now - rdata;
  assign gap = signed'(rdata - time_now);
  assign due_hit = rd_vld && (state == cto_pkg::S_SCAN) && is_tick && armed[rd_idx]
                   && !age[31];

  cto_ram #(.WIDTH(cto_pkg::TIME_W), .DEPTH(MAX_CONNECTIONS)) u_ram (
    .clk  (clk),
    .we   (accept && command == cto_pkg::CMD_ADD && in_range),
    .waddr(cid),
    .wdata(time_now + 32'(timeout_ms)),
    .raddr(cnt[IW-1:0]),
    .rdata(rdata)
  );

  // sweep bookkeeping for the word returning from the RAM
  always_comb begin
    count_next = count;
    pending_next = pending;
    any_next = any;
    best_next = best;
    found_next = found;
    best_age_next = best_age;
    pick_next = pick;
    if (rd_vld && state == cto_pkg::S_SCAN) begin
      if (due_hit) begin
        count_next = count - 7'd1;
        pending_next = pending + 7'd1;
      end else if (armed[rd_idx] && (!any || gap < best)) begin
        any_next = 1'b1;
        best_next = gap;
      end
    end
    if (rd_vld && state == cto_pkg::S_PICK) begin
      // strict compare keeps the lower id on equal age
      if (due[rd_idx] && (!found || age > best_age)) begin
        found_next = 1'b1;
        best_age_next = age;
        pick_next = rd_idx;
      end
    end
  end

  always_comb begin
    if (!any_next) begin
      nt_val = cto_pkg::NEXT_NONE;
    end else if (best_next < 0) begin
      nt_val = '0;
    end else if (best_next > 32'(cto_pkg::NEXT_MAX)) begin
      nt_val = cto_pkg::NEXT_MAX;
    end else begin
      nt_val = best_next[NT_W_FIX-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cto_pkg::S_IDLE: begin
        if (accept) state_next = cto_pkg::S_SCAN;
      end
      cto_pkg::S_SCAN: begin
        if (sweep_end) begin
          state_next = (pending_next != 7'd0) ? cto_pkg::S_PICK : cto_pkg::S_IDLE;
        end
      end
      cto_pkg::S_PICK: begin
        if (sweep_end) begin
          state_next = (pending != 7'd1) ? cto_pkg::S_PICK : cto_pkg::S_IDLE;
        end
      end
      default: state_next = cto_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cto_pkg::S_IDLE;
      time_now <= '0;
      armed <= '0;
      due <= '0;
      count <= '0;
      pending <= '0;
      cnt <= '0;
      rd_vld <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pending <= pending_next;
      done <= 1'b0;
      rd_vld <= (state != cto_pkg::S_IDLE) && !sweep_end;
      if (state != cto_pkg::S_IDLE && !sweep_end) begin
        cnt <= cnt + CW'(1);
      end else begin
        cnt <= '0;
      end
      if (due_hit) begin
        armed[rd_idx] <= 1'b0;
        due[rd_idx] <= 1'b1;
      end
      if (accept) begin
        case (command)
          cto_pkg::CMD_ADD: begin
            if (in_range) begin
              armed[cid] <= 1'b1;
              if (!armed[cid]) count <= count + 7'd1;
            end
          end
          cto_pkg::CMD_REMOVE: begin
            if (in_range && armed[cid]) begin
              armed[cid] <= 1'b0;
              count <= count - 7'd1;
            end
          end
          cto_pkg::CMD_TICK: time_now <= time_now + 32'd1;
          default: ;
        endcase
      end
      if (state == cto_pkg::S_SCAN && sweep_end && pending_next == 7'd0) begin
        done <= 1'b1;
      end
      if (state == cto_pkg::S_PICK && sweep_end) begin
        done <= 1'b1;
        due[pick_next] <= 1'b0;
        pending <= pending - 7'd1;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    rd_idx <= cnt[IW-1:0];
    any <= any_next;
    best <= best_next;
    found <= found_next;
    best_age <= best_age_next;
    pick <= pick_next;
    if (accept) begin
      is_tick <= (command == cto_pkg::CMD_TICK);
      any <= 1'b0;
      best <= '0;
      if (command == cto_pkg::CMD_ADD && in_range && armed[cid]) begin
        cmd_status <= cto_pkg::ST_REPLACED;
      end else if (command == cto_pkg::CMD_REMOVE && !(in_range && armed[cid])) begin
        cmd_status <= cto_pkg::ST_NOT_FOUND;
      end else begin
        cmd_status <= cto_pkg::ST_OK;
      end
    end
    if (state != cto_pkg::S_PICK || sweep_end) begin
      found <= 1'b0;
    end
    if (state == cto_pkg::S_SCAN && sweep_end) begin
      next_timeout <= signed'(nt_val);
      armed_count <= count_next;
      expired_valid <= 1'b0;
      expired_id <= '0;
      last <= 1'b1;
      status <= is_tick ? cto_pkg::ST_OK : cmd_status;
    end
    if (state == cto_pkg::S_PICK && sweep_end) begin
      expired_valid <= 1'b1;
      expired_id <= 6'(pick_next);
      last <= (pending == 7'd1);
      status <= cto_pkg::ST_OK;
    end
  end

`ifndef SYNTH
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    $countones(armed) == 32'(count))
    else $error("armed count out of step with armed bits");

  a_idle_no_due: assert property (@(posedge clk) disable iff (rst)
    (state == cto_pkg::S_IDLE) |-> (pending == 7'd0 && due == '0))
    else $error("due slots left over after tick");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a command in flight");

  a_expired_status: assert property (@(posedge clk) disable iff (rst)
    (done && expired_valid) |-> (status == cto_pkg::ST_OK))
    else $error("expired word carries nonzero status");
`endif

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the connection timeout table. A software model of
// the slot table predicts every word; a monitor compares each strobed word
// field by field in order. Directed tests cover the edges, then random traffic.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int NSLOT = 64;
  localparam int CYCLE_LIMIT = 10000000;

  typedef struct packed {
    logic        vld;
    logic [5:0]  id;
    logic        lst;
    logic [1:0]  st;
    logic [24:0] nt;
    logic [6:0]  cnt;
  } timer_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command = cto_pkg::CMD_ADD;
  logic [5:0]  connection_id = '0;
  logic [23:0] timeout_ms = '0;
  logic        done;
  logic        expired_valid;
  logic [5:0]  expired_id;
  logic        last;
  logic [1:0]  status;
  logic signed [24:0] next_timeout;
  logic [6:0]  armed_count;

  connection_timeout_table_top DUT (
    .clk, .rst, .start, .busy, .command, .connection_id, .timeout_ms, .done,
    .expired_valid, .expired_id, .last, .status, .next_timeout, .armed_count
  );

  always #5 clk = ~clk;

  // model of the timer table
  logic [31:0] now_ms;
  logic        armed [NSLOT];
  logic [31:0] expiry [NSLOT];
  timer_word_t pending_words [$];

  int errors = 0;
  int words_seen = 0;
  int expirations = 0;
  int cycles = 0;
  bit no_idle = 0;

  function automatic logic [24:0] earliest_remaining();
    longint best;
    bit any;
    logic [31:0] diff;
    best = 0;
    any = 0;
    for (int i = 0; i < NSLOT; i++) begin
      if (armed[i]) begin
        diff = expiry[i] - now_ms;
        if (!any || longint'($signed(diff)) < best) best = longint'($signed(diff));
        any = 1;
      end
    end
    if (!any) return cto_pkg::NEXT_NONE;
    if (best < 0) best = 0;
    if (best > 16777215) best = 16777215;
    return best[24:0];
  endfunction

  function automatic logic [6:0] armed_total();
    int c;
    c = 0;
    for (int i = 0; i < NSLOT; i++) if (armed[i]) c++;
    return c[6:0];
  endfunction

  task automatic push_word(logic vld, logic [5:0] id, logic lst, logic [1:0] st);
    timer_word_t w;
    w.vld = vld;
    w.id = id;
    w.lst = lst;
    w.st = st;
    w.nt = earliest_remaining();
    w.cnt = armed_total();
    pending_words = {pending_words, w};
  endtask

  task automatic predict_timers(logic [1:0] cmd, logic [5:0] id, logic [23:0] tmo);
    logic [1:0] st;
    bit due [NSLOT];
    int n, pick;
    logic [31:0] age, pick_age;
    st = cto_pkg::ST_OK;
    n = 0;
    case (cmd)
      cto_pkg::CMD_ADD: begin
        if (armed[id]) st = cto_pkg::ST_REPLACED;
        armed[id] = 1'b1;
        expiry[id] = now_ms + tmo;
      end
      cto_pkg::CMD_REMOVE: begin
        if (armed[id]) armed[id] = 1'b0;
        else st = cto_pkg::ST_NOT_FOUND;
      end
      cto_pkg::CMD_TICK: begin
        now_ms = now_ms + 1;
        for (int i = 0; i < NSLOT; i++) begin
          due[i] = armed[i] && !((now_ms - expiry[i]) >> 31);
          if (due[i]) begin
            n++;
            armed[i] = 1'b0;
          end
        end
        expirations += n;
        // oldest expiry first, ties to the lower id
        for (int k = n; k > 0; k--) begin
          pick = -1;
          pick_age = '0;
          for (int i = 0; i < NSLOT; i++) begin
            if (due[i]) begin
              age = now_ms - expiry[i];
              if (pick < 0 || age > pick_age) begin
                pick = i;
                pick_age = age;
              end
            end
          end
          due[pick] = 0;
          push_word(1'b1, pick[5:0], k == 1, cto_pkg::ST_OK);
        end
      end
      default: ;
    endcase
    if (n == 0) push_word(1'b0, '0, 1'b1, st);
  endtask

  // one command per call; start stays high between back-to-back commands
  task automatic send_cmd(logic [1:0] cmd, logic [5:0] id, logic [23:0] tmo);
    if (!no_idle && $urandom_range(99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    connection_id <= id;
    timeout_ms <= tmo;
    do @(posedge clk); while (busy);
    predict_timers(cmd, id, tmo);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch word %0d: %s got %0h expected %0h", words_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    timer_word_t w;
    if (!rst && done) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        w = pending_words.pop_front();
        if (expired_valid !== w.vld) report_mismatch("expired_valid", expired_valid, w.vld);
        if (expired_id !== w.id) report_mismatch("expired_id", expired_id, w.id);
        if (last !== w.lst) report_mismatch("last", last, w.lst);
        if (status !== w.st) report_mismatch("status", status, w.st);
        if (next_timeout !== w.nt) report_mismatch("next_timeout", next_timeout, w.nt);
        if (armed_count !== w.cnt) report_mismatch("armed_count", armed_count, w.cnt);
      end
      words_seen++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, pending_words.size());
      $display("FAIL connection_timeout_table_top");
      $finish;
    end
  end

  task automatic test_directed();
    send_cmd(cto_pkg::CMD_TICK, 6'd0, 24'd0);           // empty tick
    send_cmd(cto_pkg::CMD_ADD, 6'd0, 24'd0);            // due right away
    send_cmd(cto_pkg::CMD_TICK, 6'd0, 24'd0);
    send_cmd(cto_pkg::CMD_ADD, 6'd63, 24'hFFFFFF);      // saturating next timeout
    send_cmd(cto_pkg::CMD_ADD, 6'd63, 24'hFFFFFF);      // replaced
    send_cmd(cto_pkg::CMD_REMOVE, 6'd63, 24'd0);
    send_cmd(cto_pkg::CMD_REMOVE, 6'd63, 24'd0);        // not found
    send_cmd(CMD_UNUSED, 6'd42, 24'h5A5A5A);
    send_cmd(cto_pkg::CMD_ADD, 6'd30, 24'd1);           // order: 31, then tie 2 before 30
    send_cmd(cto_pkg::CMD_ADD, 6'd31, 24'd0);
    send_cmd(cto_pkg::CMD_ADD, 6'd2, 24'd1);
    send_cmd(cto_pkg::CMD_TICK, 6'd0, 24'd0);
    send_cmd(cto_pkg::CMD_ADD, 6'd21, 24'd3);
    send_cmd(cto_pkg::CMD_ADD, 6'd42, 24'd2);
    send_cmd(cto_pkg::CMD_TICK, 6'd0, 24'd0);
    send_cmd(cto_pkg::CMD_TICK, 6'd0, 24'd0);
    send_cmd(cto_pkg::CMD_TICK, 6'd0, 24'd0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < NSLOT; i++) send_cmd(cto_pkg::CMD_ADD, i[5:0], 24'(i % 3));
    send_cmd(cto_pkg::CMD_TICK, 6'd0, 24'd0);
    send_cmd(cto_pkg::CMD_TICK, 6'd0, 24'd0);
    send_cmd(cto_pkg::CMD_TICK, 6'd0, 24'd0);
  endtask

  task automatic test_random(int count);
    int r;
    logic [23:0] tmo;
    for (int n = 0; n < count; n++) begin
      no_idle = (n >= count / 3) && (n < count / 2);
      r = $urandom_range(99);
      tmo = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(12));
      if (r < 40) send_cmd(cto_pkg::CMD_TICK, 6'($urandom), 24'($urandom));
      else if (r < 78) send_cmd(cto_pkg::CMD_ADD, 6'($urandom), tmo);
      else if (r < 95) send_cmd(cto_pkg::CMD_REMOVE, 6'($urandom), 24'($urandom));
      else send_cmd(CMD_UNUSED, 6'($urandom), 24'($urandom));
    end
    no_idle = 0;
  endtask

  initial begin
    now_ms = '0;
    for (int i = 0; i < NSLOT; i++) begin
      armed[i] = 1'b0;
      expiry[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random(320);
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("checked %0d result words, %0d expirations, final time %0d ms",
             words_seen, expirations, now_ms);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("PASS connection_timeout_table_top");
    end else begin
      $display("FAIL connection_timeout_table_top");
    end
    $finish;
  end

endmodule
